// ----- rtl/sli_pkg.sv -----
// sli_pkg: shared widths and command codes for the setpoint linear interpolator
// used by the channel interfaces and the top level; no dependencies

package sli_pkg;

    // field widths
    localparam int MODE_W = 2;
    localparam int POS_W  = 32;

    // default number of ticks per setpoint interval
    localparam int NUM_STEPS_DEF = 4;

    // command codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SETPOINT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;

endpackage

// ----- rtl/sli_ifs.sv -----
// sli_ifs: valid/ready channel interfaces for the interpolator command and result words
// depends on sli_pkg for field widths

// command channel: loop tick, new setpoint or clear
interface sli_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [sli_pkg::MODE_W-1:0]       mode;
    logic signed [sli_pkg::POS_W-1:0] setpoint;

    modport source (output valid, output mode, output setpoint, input ready);
    modport sink   (input valid, input mode, input setpoint, output ready);
endinterface

// result channel: interpolated position for one tick
interface sli_pos_if;
    logic                             valid;
    logic                             ready;
    logic signed [sli_pkg::POS_W-1:0] position;
    logic                             primed;

    modport source (output valid, output position, output primed, input ready);
    modport sink   (input valid, input position, input primed, output ready);
endinterface

// ----- rtl/setpoint_linear_interpolator.sv -----
// setpoint_linear_interpolator: raises the rate of position setpoints by linear interpolation
// depends on sli_pkg and the channel interfaces in sli_ifs.sv
//
// Usage
//   cmd carries one word per cycle at most: mode tick, new setpoint or clear.
//   A setpoint word moves the old target into the start position and loads
//   the new target; the first one after reset or clear becomes both. A clear
//   word returns the block to its unprimed state. Neither gives a result.
//   Each tick word gives one result word on the result channel: the position
//   start + (target - start) * step / NUM_STEPS, or 0 with primed low
//   before any setpoint. Mode 3 is dropped without effect.
//   Path: a tick passes the input register, difference, quotient, remainder
//   and result register stages in that order before its result shows.
//   Throughput: up to one word per cycle on both channels while the result
//   channel takes its words; the stall rule below can hold the flow.
//   Stall: each stage holds while the one after it is full and not moving,
//   so with the result stalled the block still takes words until all five
//   registers are full; setpoint and clear words leave stage 1 empty behind them.
//   Reset: asynchronous, active low; the pipeline empties and the block is
//   unprimed with start, target and step count at zero.

module setpoint_linear_interpolator #(
    parameter int NUM_STEPS = sli_pkg::NUM_STEPS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sli_cmd_if.sink   cmd,
    sli_pos_if.source result
);

    localparam int POS_W  = sli_pkg::POS_W;
    localparam int MODE_W = sli_pkg::MODE_W;

    // step counter holds 0..NUM_STEPS
    localparam int STEP_W = $clog2(NUM_STEPS + 1);
    localparam int LOG_S  = $clog2(NUM_STEPS);

    // reciprocal for the magnitude quotient, exact for values below 2^POS_W
    localparam int K_A       = POS_W + LOG_S;
    localparam int RECIP_A_W = POS_W + 2;
    localparam logic [RECIP_A_W-1:0] RECIP_A = RECIP_A_W'(
        ((64'd1 << K_A) + 64'(NUM_STEPS) - 64'd1) / 64'(NUM_STEPS));
    localparam int PROD_A_W  = POS_W + RECIP_A_W;

    // reciprocal for the remainder term, exact for values below 2^X_W
    localparam int X_W       = 2 * STEP_W;
    localparam int K_X       = X_W + LOG_S;
    localparam int RECIP_X_W = X_W + 2;
    localparam logic [RECIP_X_W-1:0] RECIP_X = RECIP_X_W'(
        ((64'd1 << K_X) + 64'(NUM_STEPS) - 64'd1) / 64'(NUM_STEPS));
    localparam int PROD_X_W  = X_W + RECIP_X_W;

    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(NUM_STEPS);

    // stage enables, from the result end backwards
    logic en_r;
    logic en3;
    logic en2;
    logic en1;
    logic en0;

    // input register
    logic              s0_valid_reg;
    logic [MODE_W-1:0] s0_mode_reg;
    logic [POS_W-1:0]  s0_setpoint_reg;

    // interpolator state
    logic [POS_W-1:0]  start_reg,  start_next;
    logic [POS_W-1:0]  target_reg, target_next;
    logic [STEP_W-1:0] step_reg,   step_next;
    logic              has_setpoint_reg, has_setpoint_next;

    // stage 1: difference magnitude
    logic              s1_valid_reg, s1_valid_next;
    logic [POS_W-1:0]  s1_start_reg, s1_start_next;
    logic [POS_W-1:0]  s1_mag_reg,   s1_mag_next;
    logic              s1_neg_reg,   s1_neg_next;
    logic [STEP_W-1:0] s1_step_reg,  s1_step_next;
    logic              s1_primed_reg, s1_primed_next;

    // stage 2: magnitude quotient
    logic              s2_valid_reg;
    logic [POS_W-1:0]  s2_start_reg;
    logic [POS_W-1:0]  s2_mag_reg;
    logic [POS_W-1:0]  s2_qa_reg, s2_qa_next;
    logic              s2_neg_reg;
    logic [STEP_W-1:0] s2_step_reg;
    logic              s2_primed_reg;
    logic [PROD_A_W-1:0] prod_a;

    // stage 3: scaled quotient and remainder product
    logic              s3_valid_reg;
    logic [POS_W-1:0]  s3_start_reg;
    logic [POS_W-1:0]  s3_qs_reg, s3_qs_next;
    logic [X_W-1:0]    s3_x_reg,  s3_x_next;
    logic              s3_neg_reg;
    logic              s3_primed_reg;
    logic [POS_W-1:0]  rem_full;
    logic [STEP_W-1:0] rem;

    // result register
    logic              res_valid_reg;
    logic [POS_W-1:0]  res_pos_reg, res_pos_next;
    logic              res_primed_reg;
    logic [PROD_X_W-1:0] prod_x;
    logic [POS_W-1:0]  mag_q;
    logic [POS_W-1:0]  diff;

    // pipeline flow control
    assign en_r = !res_valid_reg || result.ready;
    assign en3  = !s3_valid_reg  || en_r;
    assign en2  = !s2_valid_reg  || en3;
    assign en1  = !s1_valid_reg  || en2;
    assign en0  = !s0_valid_reg  || en1;

    assign cmd.ready = en0;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en0)
        begin
            s0_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            s0_mode_reg     <= cmd.mode;
            s0_setpoint_reg <= $unsigned(cmd.setpoint);
        end
    end

    // command decode, state update and difference magnitude
    always_comb
    begin
        start_next        = start_reg;
        target_next       = target_reg;
        step_next         = step_reg;
        has_setpoint_next = has_setpoint_reg;
        s1_valid_next     = 1'b0;
        s1_start_next     = '0;
        s1_mag_next       = '0;
        s1_neg_next       = 1'b0;
        s1_step_next      = '0;
        s1_primed_next    = 1'b0;
        diff              = target_reg - start_reg;
        if (s0_valid_reg)
        begin
            case (s0_mode_reg)
                sli_pkg::MODE_TICK:
                begin
                    s1_valid_next = 1'b1;
                    if (has_setpoint_reg)
                    begin
                        if (step_reg < STEP_MAX)
                        begin
                            step_next = step_reg + STEP_W'(1);
                        end
                        s1_start_next  = start_reg;
                        s1_neg_next    = diff[POS_W-1];
                        s1_mag_next    = diff[POS_W-1] ? (~diff + POS_W'(1)) : diff;
                        s1_step_next   = step_next;
                        s1_primed_next = 1'b1;
                    end
                end
                sli_pkg::MODE_SETPOINT:
                begin
                    start_next        = has_setpoint_reg ? target_reg : s0_setpoint_reg;
                    target_next       = s0_setpoint_reg;
                    step_next         = '0;
                    has_setpoint_next = 1'b1;
                end
                sli_pkg::MODE_CLEAR:
                begin
                    start_next        = '0;
                    target_next       = '0;
                    step_next         = '0;
                    has_setpoint_next = 1'b0;
                end
                default:
                begin
                    s1_valid_next = 1'b0;
                end
            endcase
        end
    end

    // interpolator state, advanced as the input register empties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg        <= '0;
            target_reg       <= '0;
            step_reg         <= '0;
            has_setpoint_reg <= 1'b0;
        end
        else if (en1)
        begin
            start_reg        <= start_next;
            target_reg       <= target_next;
            step_reg         <= step_next;
            has_setpoint_reg <= has_setpoint_next;
        end
    end

    // stage 1 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_start_reg  <= s1_start_next;
            s1_mag_reg    <= s1_mag_next;
            s1_neg_reg    <= s1_neg_next;
            s1_step_reg   <= s1_step_next;
            s1_primed_reg <= s1_primed_next;
        end
    end

    // magnitude divided by the step count, by reciprocal multiply
    assign prod_a     = PROD_A_W'(s1_mag_reg) * PROD_A_W'(RECIP_A);
    assign s2_qa_next = POS_W'(prod_a >> K_A);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_start_reg  <= s1_start_reg;
            s2_mag_reg    <= s1_mag_reg;
            s2_qa_reg     <= s2_qa_next;
            s2_neg_reg    <= s1_neg_reg;
            s2_step_reg   <= s1_step_reg;
            s2_primed_reg <= s1_primed_reg;
        end
    end

    // quotient times step, remainder times step
    assign rem_full   = s2_mag_reg - POS_W'(s2_qa_reg * POS_W'(NUM_STEPS));
    assign rem        = rem_full[STEP_W-1:0];
    assign s3_qs_next = POS_W'(s2_qa_reg * POS_W'(s2_step_reg));
    assign s3_x_next  = X_W'(rem) * X_W'(s2_step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en3)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_start_reg  <= s2_start_reg;
            s3_qs_reg     <= s3_qs_next;
            s3_x_reg      <= s3_x_next;
            s3_neg_reg    <= s2_neg_reg;
            s3_primed_reg <= s2_primed_reg;
        end
    end

    // remainder term quotient, sign and offset from the start position
    assign prod_x       = PROD_X_W'(s3_x_reg) * PROD_X_W'(RECIP_X);
    assign mag_q        = s3_qs_reg + POS_W'(prod_x >> K_X);
    assign res_pos_next = s3_start_reg + (s3_neg_reg ? (~mag_q + POS_W'(1)) : mag_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en_r)
        begin
            res_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_r)
        begin
            res_pos_reg    <= res_pos_next;
            res_primed_reg <= s3_primed_reg;
        end
    end

    assign result.valid    = res_valid_reg;
    assign result.position = $signed(res_pos_reg);
    assign result.primed   = res_primed_reg;

`ifndef SYNTHESIS
    // unprimed ticks always read as zero
    a_unprimed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.primed |-> result.position == '0)
        else $error("unprimed result with nonzero position");

    // unprimed state holds its reset values
    a_unprimed_state: assert property (@(posedge clk) disable iff (!rst_n)
        !has_setpoint_reg |-> start_reg == '0 && target_reg == '0 && step_reg == '0)
        else $error("unprimed interpolator with stale state");

    // step counter saturates at the steps per interval
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_MAX)
        else $error("step counter beyond steps per interval");

    // a clear leaving the input register unprimes the block
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg && en1 && s0_mode_reg == sli_pkg::MODE_CLEAR |=> !has_setpoint_reg)
        else $error("clear word did not unprime the block");
`endif

endmodule
